// ===== src/lvm_pkg.sv =====
// ============================================================================
// lvm_pkg: shared types and constants for the look-at view matrix block
// Fixed-point widths, pipeline depths and configuration register indexes.
// ============================================================================
package lvm_pkg;

    // Field types
    typedef logic signed [31:0] t_coord;   // Q16.16 position / translation
    typedef logic signed [17:0] t_unit;    // Q1.16 unit-vector component

    // Configuration register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_UP_X = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_UP_Y = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_UP_Z = 2'd2;

    // Normalizer datapath widths
    localparam int NW       = 36;   // signed vector component entering a normalizer
    localparam int BLW      = 6;    // bit length of a magnitude, 0..NW
    localparam int MW       = 30;   // magnitude after alignment, top bit at bit 29
    localparam int SW       = 63;   // square-root working width
    localparam int SQ_STEPS = 32;   // one result bit per stage
    localparam int LW       = 31;   // root (vector length) width
    localparam int FRAC     = 16;   // Q1.16 fraction bits
    localparam int QW       = 17;   // quotient width, at most 65536
    localparam int DW       = MW + FRAC + 2;  // dividend / remainder width

    // Normalizer latency: abs, align, square, sum, root, divide, sign
    localparam int NORM_LAT = 4 + SQ_STEPS + QW + 1;
    // Spacing between normalizer outputs (normalizer plus cross product)
    localparam int DLY      = NORM_LAT + 2;
    localparam int EYE_DLY  = 3 * DLY - 2;

    // Translation datapath
    localparam int PW       = 50;   // unit x coordinate product
    localparam int SUMW     = 52;   // dot product sum
    localparam int RNDW     = SUMW - FRAC;

endpackage

// ===== src/lvm_in_if.sv =====
// ============================================================================
// lvm_in_if: input channel of the view matrix block
// Eye and target position beat with valid / ready handshake.
// ============================================================================
interface lvm_in_if;
    logic            valid;
    logic            ready;
    lvm_pkg::t_coord eye_x;
    lvm_pkg::t_coord eye_y;
    lvm_pkg::t_coord eye_z;
    lvm_pkg::t_coord target_x;
    lvm_pkg::t_coord target_y;
    lvm_pkg::t_coord target_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    output ready);
endinterface

// ===== src/lvm_out_if.sv =====
// ============================================================================
// lvm_out_if: output channel of the view matrix block
// Camera basis vectors and translation beat with valid / ready handshake.
// ============================================================================
interface lvm_out_if;
    logic            valid;
    logic            ready;
    lvm_pkg::t_unit  right_x;
    lvm_pkg::t_unit  right_y;
    lvm_pkg::t_unit  right_z;
    lvm_pkg::t_unit  upv_x;
    lvm_pkg::t_unit  upv_y;
    lvm_pkg::t_unit  upv_z;
    lvm_pkg::t_unit  back_x;
    lvm_pkg::t_unit  back_y;
    lvm_pkg::t_unit  back_z;
    lvm_pkg::t_coord trans_right;
    lvm_pkg::t_coord trans_up;
    lvm_pkg::t_coord trans_back;

    modport source (output valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
                    back_x, back_y, back_z, trans_right, trans_up, trans_back,
                    input ready);
    modport sink   (input valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
                    back_x, back_y, back_z, trans_right, trans_up, trans_back,
                    output ready);
endinterface

// ===== src/lvm_norm.sv =====
// ============================================================================
// lvm_norm: pipelined 3-vector normalizer
// Aligns the magnitudes, takes an integer square root one bit per stage and
// divides each component by the length one quotient bit per stage.
// ============================================================================
module lvm_norm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  logic                         i_valid,
    input  logic signed [lvm_pkg::NW-1:0] i_v [3],
    output logic                         o_valid,
    output lvm_pkg::t_unit               o_v [3]
);
    import lvm_pkg::*;

    typedef struct packed {
        logic [2:0][MW-1:0] m;
        logic [2:0]         neg;
        logic               zero;
    } t_side;

    // ------------------------------------------------------------------
    // Stage 1: magnitudes, signs, bit length of the largest
    // ------------------------------------------------------------------
    logic [NW-1:0]  n_mag [3];
    logic [2:0]     n_neg;
    logic [NW-1:0]  n_any;
    logic [BLW-1:0] n_bl;

    always_comb begin
        n_any = '0;
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = i_v[i][NW-1];
            n_mag[i] = n_neg[i] ? NW'(-i_v[i]) : NW'(i_v[i]);
            n_any    = n_any | n_mag[i];
        end
        n_bl = '0;
        for (int b = 0; b < NW; b++) begin
            if (n_any[b]) begin
                n_bl = BLW'(b + 1);
            end
        end
    end

    logic [NW-1:0]  r1_mag [3];
    logic [2:0]     r1_neg;
    logic [BLW-1:0] r1_bl;
    logic           r1_zero;
    logic           r1_v;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_mag  <= n_mag;
            r1_neg  <= n_neg;
            r1_bl   <= n_bl;
            r1_zero <= (n_any == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: shift so the largest magnitude tops out at bit MW-1
    // ------------------------------------------------------------------
    logic [NW-1:0] n_sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r1_bl > BLW'(MW)) begin
                n_sh[i] = r1_mag[i] >> (r1_bl - BLW'(MW));
            end else begin
                n_sh[i] = r1_mag[i] << (BLW'(MW) - r1_bl);
            end
        end
    end

    t_side r2_s;
    logic  r2_v;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r2_s.m[i] <= n_sh[i][MW-1:0];
            end
            r2_s.neg  <= r1_neg;
            r2_s.zero <= r1_zero;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares; stage 4: sum of squares
    // ------------------------------------------------------------------
    logic [2*MW-1:0] r3_sq [3];
    t_side           r3_s;
    logic            r3_v;
    logic [SW-1:0]   r4_sum;
    t_side           r4_s;
    logic            r4_v;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= (2*MW)'(r2_s.m[i]) * (2*MW)'(r2_s.m[i]);
            end
            r3_s   <= r2_s;
            r4_sum <= SW'(r3_sq[0]) + SW'(r3_sq[1]) + SW'(r3_sq[2]);
            r4_s   <= r3_s;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage
    // ------------------------------------------------------------------
    logic [SW-1:0]     rs_x [SQ_STEPS+1];
    logic [SW-1:0]     rs_r [SQ_STEPS+1];
    t_side             rs_s [SQ_STEPS+1];
    logic              rs_v [SQ_STEPS+1];

    assign rs_x[0] = r4_sum;
    assign rs_r[0] = '0;
    assign rs_s[0] = r4_s;
    assign rs_v[0] = r4_v;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SW-1:0] BITV = SW'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [SW-1:0] trial;

        assign trial = rs_r[k] + BITV;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rs_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                rs_v[k+1] <= rs_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                rs_s[k+1] <= rs_s[k];
                if (rs_x[k] >= trial) begin
                    rs_x[k+1] <= rs_x[k] - trial;
                    rs_r[k+1] <= (rs_r[k] >> 1) + BITV;
                end else begin
                    rs_x[k+1] <= rs_x[k];
                    rs_r[k+1] <= rs_r[k] >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Division: (m * 2^16 + len / 2) / len, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DW-1:0] rd_rem [QW+1][3];
    logic [QW-1:0] rd_q   [QW+1][3];
    logic [LW-1:0] rd_len [QW+1];
    t_side         rd_s   [QW+1];
    logic          rd_v   [QW+1];

    always_comb begin
        rd_len[0] = rs_r[SQ_STEPS][LW-1:0];
        rd_s[0]   = rs_s[SQ_STEPS];
        rd_v[0]   = rs_v[SQ_STEPS];
        for (int i = 0; i < 3; i++) begin
            rd_rem[0][i] = (DW'(rs_s[SQ_STEPS].m[i]) << FRAC) + DW'(rd_len[0] >> 1);
            rd_q[0][i]   = '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int SH = QW - 1 - k;
        logic [DW-1:0] trial;

        assign trial = DW'(rd_len[k]) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rd_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                rd_v[k+1] <= rd_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                rd_len[k+1] <= rd_len[k];
                rd_s[k+1]   <= rd_s[k];
                for (int i = 0; i < 3; i++) begin
                    if (rd_rem[k][i] >= trial) begin
                        rd_rem[k+1][i] <= rd_rem[k][i] - trial;
                        rd_q[k+1][i]   <= rd_q[k][i] | (QW'(1) << SH);
                    end else begin
                        rd_rem[k+1][i] <= rd_rem[k][i];
                        rd_q[k+1][i]   <= rd_q[k][i];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: apply sign, zero vector stays zero
    // ------------------------------------------------------------------
    t_unit r_o [3];
    logic  r_ov;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                if (rd_s[QW].zero) begin
                    r_o[i] <= '0;
                end else if (rd_s[QW].neg[i]) begin
                    r_o[i] <= -$signed({1'b0, rd_q[QW][i]});
                end else begin
                    r_o[i] <= $signed({1'b0, rd_q[QW][i]});
                end
            end
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_ce) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_ov <= rd_v[QW];
        end
    end

    assign o_valid = r_ov;
    assign o_v     = r_o;

endmodule

// ===== src/look_at_view_matrix_top.sv =====
// ============================================================================
// look_at_view_matrix_top: fixed-point camera view matrix
// Builds right, up and back vectors and the eye translation from an eye and
// target position and a configured world-up vector.
// ============================================================================
// Fully pipelined: one eye/target beat is accepted every cycle the pipeline
// advances; each beat passes the input register, three 54-stage normalizers,
// two 2-stage cross products and a 2-stage translation. Throughput is set
// by the pipeline's shared clock enable: the whole pipeline holds only while
// a finished beat sits in the output register and the sink is not ready.
// Normalizers use a one-bit-per-stage square root and a one-bit-per-stage
// divider. The world-up registers are read when a beat reaches the first
// cross product, so write them only while the pipeline is empty.
module look_at_view_matrix_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lvm_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  lvm_pkg::t_unit              i_cfg_data,
    lvm_in_if.sink                      i_in,
    lvm_out_if.source                   o_out
);
    import lvm_pkg::*;

    // ------------------------------------------------------------------
    // World-up registers
    // ------------------------------------------------------------------
    t_unit r_up [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up[0] <= '0;
            r_up[1] <= t_unit'(1 << FRAC);
            r_up[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UP_X: r_up[0] <= i_cfg_data;
                CFG_UP_Y: r_up[1] <= i_cfg_data;
                CFG_UP_Z: r_up[2] <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Pipeline clock enable: advance unless the output beat is stuck
    logic ce;
    logic r_ov;

    assign ce         = !r_ov || o_out.ready;
    assign i_in.ready = ce;

    // ------------------------------------------------------------------
    // Stage 0: capture eye, form target - eye
    // ------------------------------------------------------------------
    logic signed [NW-1:0] r0_d [3];
    t_coord               r0_eye [3];
    logic                 r0_v;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0_eye[0] <= i_in.eye_x;
            r0_eye[1] <= i_in.eye_y;
            r0_eye[2] <= i_in.eye_z;
            r0_d[0]   <= NW'(i_in.target_x) - NW'(i_in.eye_x);
            r0_d[1]   <= NW'(i_in.target_y) - NW'(i_in.eye_y);
            r0_d[2]   <= NW'(i_in.target_z) - NW'(i_in.eye_z);
        end
    end

    // Forward direction
    t_unit f [3];
    logic  f_v;

    lvm_norm u_norm_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r0_v),
        .i_v     (r0_d),
        .o_valid (f_v),
        .o_v     (f)
    );

    // ------------------------------------------------------------------
    // Cross 1: world-up x forward
    // ------------------------------------------------------------------
    logic signed [NW-1:0] r_c1p [6];
    logic                 r_c1v;
    logic signed [NW-1:0] r_t1 [3];
    logic                 r_t1v;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c1p[0] <= NW'(r_up[1]) * NW'(f[2]);
            r_c1p[1] <= NW'(r_up[2]) * NW'(f[1]);
            r_c1p[2] <= NW'(r_up[2]) * NW'(f[0]);
            r_c1p[3] <= NW'(r_up[0]) * NW'(f[2]);
            r_c1p[4] <= NW'(r_up[0]) * NW'(f[1]);
            r_c1p[5] <= NW'(r_up[1]) * NW'(f[0]);
            r_t1[0]  <= r_c1p[0] - r_c1p[1];
            r_t1[1]  <= r_c1p[2] - r_c1p[3];
            r_t1[2]  <= r_c1p[4] - r_c1p[5];
        end
    end

    // Right vector
    t_unit rv [3];
    logic  rv_v;

    lvm_norm u_norm_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_t1v),
        .i_v     (r_t1),
        .o_valid (rv_v),
        .o_v     (rv)
    );

    // ------------------------------------------------------------------
    // Delay lines: forward, right and eye follow the later stages
    // ------------------------------------------------------------------
    t_unit  r_fdl [2*DLY][3];
    t_unit  r_rdl [DLY][3];
    t_coord r_edl [EYE_DLY][3];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_fdl[0] <= f;
            r_rdl[0] <= rv;
            r_edl[0] <= r0_eye;
            for (int j = 1; j < 2*DLY; j++) begin
                r_fdl[j] <= r_fdl[j-1];
            end
            for (int j = 1; j < DLY; j++) begin
                r_rdl[j] <= r_rdl[j-1];
            end
            for (int j = 1; j < EYE_DLY; j++) begin
                r_edl[j] <= r_edl[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Cross 2: forward x right
    // ------------------------------------------------------------------
    t_unit                fa [3];
    logic signed [NW-1:0] r_c2p [6];
    logic                 r_c2v;
    logic signed [NW-1:0] r_t2 [3];
    logic                 r_t2v;

    assign fa = r_fdl[DLY-1];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c2p[0] <= NW'(fa[1]) * NW'(rv[2]);
            r_c2p[1] <= NW'(fa[2]) * NW'(rv[1]);
            r_c2p[2] <= NW'(fa[2]) * NW'(rv[0]);
            r_c2p[3] <= NW'(fa[0]) * NW'(rv[2]);
            r_c2p[4] <= NW'(fa[0]) * NW'(rv[1]);
            r_c2p[5] <= NW'(fa[1]) * NW'(rv[0]);
            r_t2[0]  <= r_c2p[0] - r_c2p[1];
            r_t2[1]  <= r_c2p[2] - r_c2p[3];
            r_t2[2]  <= r_c2p[4] - r_c2p[5];
        end
    end

    // Camera up vector
    t_unit uv [3];
    logic  uv_v;

    lvm_norm u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_t2v),
        .i_v     (r_t2),
        .o_valid (uv_v),
        .o_v     (uv)
    );

    // ------------------------------------------------------------------
    // Translation stage 1: column x eye products, basis vectors aligned
    // ------------------------------------------------------------------
    t_unit             bv [3];
    t_unit             rb [3];
    t_coord            eb [3];
    t_unit             r_pr [3];
    t_unit             r_pu [3];
    t_unit             r_pb [3];
    logic signed [PW-1:0] r_dr [3];
    logic signed [PW-1:0] r_du [3];
    logic signed [PW-1:0] r_db [3];
    logic              r_pv;

    assign rb = r_rdl[DLY-1];
    assign eb = r_edl[EYE_DLY-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bv[i] = -r_fdl[2*DLY-1][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pr <= rb;
            r_pu <= uv;
            r_pb <= bv;
            for (int i = 0; i < 3; i++) begin
                r_dr[i] <= PW'(rb[i]) * PW'(eb[i]);
                r_du[i] <= PW'(uv[i]) * PW'(eb[i]);
                r_db[i] <= PW'(bv[i]) * PW'(eb[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Translation stage 2: negate, round to Q16.16, saturate
    // ------------------------------------------------------------------
    function automatic t_coord f_trans(input logic signed [PW-1:0] a,
                                       input logic signed [PW-1:0] b,
                                       input logic signed [PW-1:0] c);
        logic signed [SUMW-1:0] n;
        logic signed [RNDW-1:0] q;
        n = -(SUMW'(a) + SUMW'(b) + SUMW'(c)) + SUMW'(1 << (FRAC - 1));
        q = RNDW'(n >>> FRAC);
        if (q[RNDW-1:31] == '0 || q[RNDW-1:31] == '1) begin
            f_trans = q[31:0];
        end else if (q[RNDW-1]) begin
            f_trans = {1'b1, 31'b0};
        end else begin
            f_trans = {1'b0, {31{1'b1}}};
        end
    endfunction

    t_unit  r_or [3];
    t_unit  r_ou [3];
    t_unit  r_ob [3];
    t_coord r_tr;
    t_coord r_tu;
    t_coord r_tb;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_or <= r_pr;
            r_ou <= r_pu;
            r_ob <= r_pb;
            r_tr <= f_trans(r_dr[0], r_dr[1], r_dr[2]);
            r_tu <= f_trans(r_du[0], r_du[1], r_du[2]);
            r_tb <= f_trans(r_db[0], r_db[1], r_db[2]);
        end
    end

    // Valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v  <= 1'b0;
            r_c1v <= 1'b0;
            r_t1v <= 1'b0;
            r_c2v <= 1'b0;
            r_t2v <= 1'b0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else if (ce) begin
            r0_v  <= i_in.valid;
            r_c1v <= f_v;
            r_t1v <= r_c1v;
            r_c2v <= rv_v;
            r_t2v <= r_c2v;
            r_pv  <= uv_v;
            r_ov  <= r_pv;
        end
    end

    // Output port
    assign o_out.valid       = r_ov;
    assign o_out.right_x     = r_or[0];
    assign o_out.right_y     = r_or[1];
    assign o_out.right_z     = r_or[2];
    assign o_out.upv_x       = r_ou[0];
    assign o_out.upv_y       = r_ou[1];
    assign o_out.upv_z       = r_ou[2];
    assign o_out.back_x      = r_ob[0];
    assign o_out.back_y      = r_ob[1];
    assign o_out.back_z      = r_ob[2];
    assign o_out.trans_right = r_tr;
    assign o_out.trans_up    = r_tu;
    assign o_out.trans_back  = r_tb;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input only stalls behind a stuck output beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output back-pressure");

    // Right x and back z unit components stay within one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.right_x <= 18'sd65536 && o_out.right_x >= -18'sd65536
                      && o_out.back_z <= 18'sd65536 && o_out.back_z >= -18'sd65536))
        else $error("unit vector component out of range");

    // A zero right vector forces a zero up vector and a zero up translation
    a_zero_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.right_x == '0 && o_out.right_y == '0
         && o_out.right_z == '0)
        |-> (o_out.upv_x == '0 && o_out.upv_y == '0 && o_out.upv_z == '0
             && o_out.trans_up == '0))
        else $error("up vector nonzero with zero right vector");

    // A zero back vector gives a zero back translation
    a_zero_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.back_x == '0 && o_out.back_y == '0
         && o_out.back_z == '0) |-> (o_out.trans_back == '0))
        else $error("back translation nonzero with zero back vector");

endmodule
